// ----- rtl/trio_read_kmer_binner_assert.svh -----
// ----------------------------------------------------------------------------
// trio read k-mer binner assertion macros
// Shorthand for clocked implication checks, reset-qualified on rst_ni.
// ----------------------------------------------------------------------------
`ifndef TRIO_READ_KMER_BINNER_ASSERT_SVH
`define TRIO_READ_KMER_BINNER_ASSERT_SVH

// same-cycle implication
`define TRB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/trb_pkg.sv -----
// ----------------------------------------------------------------------------
// trb_pkg
// Shared widths, codes and defaults of the trio read k-mer binner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trb_pkg;

  // default build parameters
  localparam int unsigned MAX_K_DEF      = 10;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned KMER_W     = 20;
  localparam int unsigned BASE_W     = 2;
  localparam int unsigned BIN_W      = 2;
  localparam int unsigned HITS_W     = 16;
  localparam int unsigned KLEN_W     = 4;
  localparam int unsigned MINH_W     = 16;
  localparam int unsigned RATIO_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // item function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // bin codes
  localparam logic [BIN_W-1:0] BIN_ONE  = 2'd0;
  localparam logic [BIN_W-1:0] BIN_TWO  = 2'd1;
  localparam logic [BIN_W-1:0] BIN_BOTH = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DEN   = 2'd3;

  // register reset values
  localparam logic [KLEN_W-1:0]  KMER_LENGTH_RST = 4'd10;
  localparam logic [MINH_W-1:0]  MIN_HITS_RST    = 16'd10;
  localparam logic [RATIO_W-1:0] RATIO_NUM_RST   = 8'd3;
  localparam logic [RATIO_W-1:0] RATIO_DEN_RST   = 8'd2;

endpackage

`default_nettype wire

// ----- rtl/trb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// trb_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface trb_cfg_if;
  import trb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/trb_in_if.sv -----
// ----------------------------------------------------------------------------
// trb_in_if
// Input word channel: insert k-mer or read base, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface trb_in_if;
  import trb_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic              parent_sel;
  logic [KMER_W-1:0] kmer_value;
  logic [BASE_W-1:0] base_code;
  logic              read_end;

  modport source (output valid, output func, output parent_sel, output kmer_value,
                  output base_code, output read_end, input ready);
  modport sink   (input valid, input func, input parent_sel, input kmer_value,
                  input base_code, input read_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/trb_out_if.sv -----
// ----------------------------------------------------------------------------
// trb_out_if
// Result word channel: bin decision and hit counts, valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface trb_out_if;
  import trb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BIN_W-1:0]  bin;
  logic [HITS_W-1:0] hits_one;
  logic [HITS_W-1:0] hits_two;

  modport source (output valid, output bin, output hits_one, output hits_two, input ready);
  modport sink   (input valid, input bin, input hits_one, input hits_two, output ready);
endinterface

`default_nettype wire

// ----- rtl/trio_read_kmer_binner.sv -----
// ----------------------------------------------------------------------------
// trio_read_kmer_binner
// Bins reads between two parents by k-mer membership lookups.
//
//   channel  dir  word
//   cfg_i    in   register index, write data
//   in_i     in   func, parent_sel, kmer_value, base_code, read_end
//   out_o    out  bin, hits_one, hits_two (one per read, on its last base)
//
// One input word per cycle; the membership ram does one read and one write a
// cycle. A result passes through the lookup, count, select, multiply and
// output registers after its last base. After reset a clearing pass runs over
// every address of the membership ram with in_i.ready low; cfg_i is
// always ready. A stalled output fills the result stages before in_i stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "trio_read_kmer_binner_assert.svh"

module trio_read_kmer_binner #(
  parameter int unsigned MAX_K      = trb_pkg::MAX_K_DEF,
  parameter int unsigned COUNT_BITS = trb_pkg::COUNT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  trb_cfg_if.sink         cfg_i,
  trb_in_if.sink          in_i,
  trb_out_if.source       out_o
);
  import trb_pkg::*;

  localparam int unsigned WIN_W = 2 * MAX_K;
  localparam int unsigned DEPTH = 2 ** WIN_W;
  localparam int unsigned KW    = $clog2(MAX_K + 1);
  localparam int unsigned PW    = COUNT_BITS + RATIO_W;
  localparam int unsigned CMP_W = (COUNT_BITS > MINH_W) ? COUNT_BITS : MINH_W;

  // configuration registers
  logic [KLEN_W-1:0]  kmer_length_q;
  logic [MINH_W-1:0]  min_hits_q;
  logic [RATIO_W-1:0] ratio_num_q;
  logic [RATIO_W-1:0] ratio_den_q;

  // config write port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KMER_LENGTH_RST;
      min_hits_q    <= MIN_HITS_RST;
      ratio_num_q   <= RATIO_NUM_RST;
      ratio_den_q   <= RATIO_DEN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_KMER_LENGTH: kmer_length_q <= cfg_i.data[KLEN_W-1:0];
        CFG_MIN_HITS:    min_hits_q    <= cfg_i.data[MINH_W-1:0];
        CFG_RATIO_NUM:   ratio_num_q   <= cfg_i.data[RATIO_W-1:0];
        CFG_RATIO_DEN:   ratio_den_q   <= cfg_i.data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // effective k and its index mask
  logic [KW-1:0]    k_eff;
  logic [WIN_W-1:0] kmask;

  always_comb begin
    if (kmer_length_q == '0) begin
      k_eff = KW'(1);
    end else if (kmer_length_q > KLEN_W'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(kmer_length_q);
    end
  end

  assign kmask = ~({WIN_W{1'b1}} << {k_eff, 1'b0});

  // clearing pass over the membership ram
  logic             clr_q;
  logic [WIN_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + WIN_W'(1);
      if (clr_addr_q == {WIN_W{1'b1}}) begin
        clr_q <= 1'b0;
      end
    end
  end

  // pipeline enables, back to front
  logic o_v_q, d_v_q, c_v_q, b_v_q, a_v_q, a_last_q;
  logic en_o, en_d, en_c, en_b, en_a, a_leave;

  assign en_o    = !o_v_q || out_o.ready;
  assign en_d    = !d_v_q || en_o;
  assign en_c    = !c_v_q || en_d;
  assign en_b    = !b_v_q || en_c;
  assign en_a    = !(a_v_q && a_last_q) || en_b;
  assign a_leave = a_v_q && en_a;

  assign in_i.ready = !clr_q && en_a;

  logic in_fire, rd_fire, ins_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign rd_fire  = in_fire && (in_i.func == FUNC_READ);
  assign ins_fire = in_fire && (in_i.func == FUNC_INSERT);

  // rolling window and base count
  logic [WIN_W-1:0] win_q, win_d;
  logic [KW-1:0]    seen_q, seen_nx;
  logic             lookup;

  assign win_d   = (win_q << 2) | WIN_W'(in_i.base_code);
  assign seen_nx = (seen_q < k_eff) ? seen_q + KW'(1) : seen_q;
  assign lookup  = (seen_nx >= k_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      seen_q <= '0;
    end else if (rd_fire) begin
      win_q  <= in_i.read_end ? '0 : win_d;
      seen_q <= in_i.read_end ? '0 : seen_nx;
    end
  end

  // membership ram, one bit array per parent
  logic             mem_one [DEPTH];
  logic             mem_two [DEPTH];
  logic [WIN_W-1:0] wr_addr, rd_addr;
  logic             we_one, we_two;
  logic             rd_one_q, rd_two_q;

  assign wr_addr = clr_q ? clr_addr_q : (WIN_W'(in_i.kmer_value) & kmask);
  assign we_one  = clr_q || (ins_fire && !in_i.parent_sel);
  assign we_two  = clr_q || (ins_fire && in_i.parent_sel);
  assign rd_addr = win_d & kmask;

  always_ff @(posedge clk_i) begin
    if (we_one) begin
      mem_one[wr_addr] <= !clr_q;
    end
    if (rd_fire) begin
      rd_one_q <= mem_one[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_two) begin
      mem_two[wr_addr] <= !clr_q;
    end
    if (rd_fire) begin
      rd_two_q <= mem_two[rd_addr];
    end
  end

  // stage a: lookup result in flight
  logic a_look_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_a) begin
      a_v_q <= rd_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      a_last_q <= in_i.read_end;
      a_look_q <= lookup;
    end
  end

  // saturating hit counters
  logic [COUNT_BITS-1:0] cnt1_q, cnt2_q, cnt1_nx, cnt2_nx;
  logic                  hit1, hit2;

  assign hit1    = a_look_q && rd_one_q;
  assign hit2    = a_look_q && !rd_one_q && rd_two_q;
  assign cnt1_nx = (hit1 && (cnt1_q != {COUNT_BITS{1'b1}})) ? cnt1_q + COUNT_BITS'(1) : cnt1_q;
  assign cnt2_nx = (hit2 && (cnt2_q != {COUNT_BITS{1'b1}})) ? cnt2_q + COUNT_BITS'(1) : cnt2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q <= '0;
      cnt2_q <= '0;
    end else if (a_leave) begin
      cnt1_q <= a_last_q ? '0 : cnt1_nx;
      cnt2_q <= a_last_q ? '0 : cnt2_nx;
    end
  end

  // stage b: final counts of a read
  logic [COUNT_BITS-1:0] b_c1_q, b_c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_b) begin
      b_v_q <= a_leave && a_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_c1_q <= cnt1_nx;
      b_c2_q <= cnt2_nx;
    end
  end

  // stage c: larger and smaller count
  logic                  b_first;
  logic                  c_first_q;
  logic [COUNT_BITS-1:0] c_large_q, c_small_q;
  logic [HITS_W-1:0]     c_h1_q, c_h2_q;

  assign b_first = !(b_c1_q < b_c2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en_c) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c_first_q <= b_first;
      c_large_q <= b_first ? b_c1_q : b_c2_q;
      c_small_q <= b_first ? b_c2_q : b_c1_q;
      c_h1_q    <= HITS_W'(b_c1_q);
      c_h2_q    <= HITS_W'(b_c2_q);
    end
  end

  // stage d: ratio products and threshold check
  logic          d_first_q, d_min_ok_q, d_small_zero_q;
  logic [PW-1:0] d_pl_q, d_ps_q;
  logic [HITS_W-1:0] d_h1_q, d_h2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en_d) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      d_first_q      <= c_first_q;
      d_min_ok_q     <= (CMP_W'(c_large_q) >= CMP_W'(min_hits_q));
      d_small_zero_q <= (c_small_q == '0);
      d_pl_q         <= PW'(c_large_q) * PW'(ratio_den_q);
      d_ps_q         <= PW'(c_small_q) * PW'(ratio_num_q);
      d_h1_q         <= c_h1_q;
      d_h2_q         <= c_h2_q;
    end
  end

  // output register: bin decision
  logic              single;
  logic [BIN_W-1:0]  o_bin_q;
  logic [HITS_W-1:0] o_h1_q, o_h2_q;

  assign single = d_min_ok_q && (d_small_zero_q || (d_pl_q >= d_ps_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en_o) begin
      o_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      o_bin_q <= !single ? BIN_BOTH : (d_first_q ? BIN_ONE : BIN_TWO);
      o_h1_q  <= d_h1_q;
      o_h2_q  <= d_h2_q;
    end
  end

  assign out_o.valid    = o_v_q;
  assign out_o.bin      = o_bin_q;
  assign out_o.hits_one = o_h1_q;
  assign out_o.hits_two = o_h2_q;

  // checks
  `TRB_ASSERT_IMP(a_no_accept_in_clear, in_fire, !clr_q, "word accepted during clearing pass")
  `TRB_ASSERT_NXT(a_clear_done_stays, !clr_q, !clr_q, "clearing pass restarted")
  `TRB_ASSERT_NXT(a_counts_cleared, a_leave && a_last_q, (cnt1_q == '0) && (cnt2_q == '0),
                  "hit counters not cleared after last base")
  `TRB_ASSERT_NXT(a_last_reaches_b, a_leave && a_last_q, b_v_q, "read end lost before decision")
  `TRB_ASSERT_IMP(a_bin_code, o_v_q, (o_bin_q == BIN_ONE) || (o_bin_q == BIN_TWO) ||
                  (o_bin_q == BIN_BOTH), "invalid bin code on output")

endmodule

`default_nettype wire
